/* rtl/fac_pkg.sv */
// Shared types and constants of the fit allocator.
`default_nettype none
package fac_pkg;

    localparam int IDX_W   = 10;
    localparam int ADDR_W  = 16;
    localparam int LEN_W   = 17;
    localparam int BYTES_W = 21;
    localparam int WB_W    = 5;
    localparam int QUO_W   = BYTES_W + 1;
    localparam int CFG_W   = 17;

    localparam int DEF_MAX_HOLES  = 64;
    localparam int DEF_MAX_BLOCKS = 64;
    localparam int DEF_POOL_LIMIT = 65536;

    localparam logic [1:0] REQ_ALLOC  = 2'd0;
    localparam logic [1:0] REQ_FREE   = 2'd1;
    localparam logic [1:0] REQ_REINIT = 2'd2;

    localparam logic [1:0] CFG_POOL_WORDS = 2'd0;
    localparam logic [1:0] CFG_WORD_BYTES = 2'd1;
    localparam logic [1:0] CFG_FIT_POLICY = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ZERO     = 3'd1;
    localparam logic [2:0] ST_FEW      = 3'd2;
    localparam logic [2:0] ST_NOFIT    = 3'd3;
    localparam logic [2:0] ST_NOTALLOC = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    typedef enum logic [2:0] {
        HOP_HOLD,
        HOP_ROT,
        HOP_UPD,
        HOP_DEL,
        HOP_INS,
        HOP_CLR
    } hole_op_t;

    typedef enum logic [2:0] {
        BOP_HOLD,
        BOP_ROT,
        BOP_SET,
        BOP_CLRV,
        BOP_CLRALL
    } blk_op_t;

    typedef struct packed {
        hole_op_t           op;
        logic [IDX_W-1:0]   idx;
        logic [ADDR_W-1:0]  start;
        logic [LEN_W-1:0]   len;
    } hole_ctl_t;

    typedef struct packed {
        blk_op_t            op;
        logic [IDX_W-1:0]   idx;
        logic [ADDR_W-1:0]  start;
        logic [LEN_W-1:0]   len;
    } blk_ctl_t;

endpackage
`default_nettype wire

/* rtl/fit_allocator_with_coalescing_core.sv */
// Top level of the fit allocator: control sequencer, divider and the two cell chains.
//
//   channel | direction | handshake            | payload
//   cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//   in      | in        | in_valid/in_ready    | req_type, request_bytes, block_offset
//   out     | out       | out_valid/out_ready  | granted_offset, status, free_words
//
// One request at a time. An allocate runs the bit-serial rounding divider, then one
// full rotation of both cell chains past the scan point, S = max(MAX_HOLES,
// MAX_BLOCKS) entries, then evaluation; a free skips the divider, and it passes
// through S_REMOVE as well when it merges with holes on both sides.
// Reset and reinitialize leave one hole covering the pool (none for an empty pool) and no allocated blocks.
// A finished beat waits in the output register; the next beat is taken meanwhile,
// and only its own result waits for the output register to drain.
`default_nettype none
module fit_allocator_with_coalescing_core #(
    parameter int MAX_HOLES  = fac_pkg::DEF_MAX_HOLES,
    parameter int MAX_BLOCKS = fac_pkg::DEF_MAX_BLOCKS,
    parameter int POOL_LIMIT = fac_pkg::DEF_POOL_LIMIT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [1:0]                   cfg_index,
    input  wire logic [fac_pkg::CFG_W-1:0]    cfg_data,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [1:0]                   req_type,
    input  wire logic [fac_pkg::BYTES_W-1:0]  request_bytes,
    input  wire logic [fac_pkg::ADDR_W-1:0]   block_offset,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic      [fac_pkg::ADDR_W-1:0]   granted_offset,
    output logic      [2:0]                   status,
    output logic      [fac_pkg::LEN_W-1:0]    free_words
);
    import fac_pkg::*;

    localparam int SCAN_N = (MAX_HOLES > MAX_BLOCKS) ? MAX_HOLES : MAX_BLOCKS;
    localparam int SC_W   = $clog2(SCAN_N + 1);
    localparam int HW     = $clog2(MAX_HOLES);
    localparam int CW     = $clog2(MAX_HOLES + 1);
    localparam int BW     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CMP_W  = IDX_W + 2;
    localparam int DIV_W  = $clog2(QUO_W);
    localparam logic [LEN_W-1:0] LIMIT = LEN_W'(POOL_LIMIT);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DIV    = 6'b000010,
        S_SCAN   = 6'b000100,
        S_EVAL   = 6'b001000,
        S_REMOVE = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [LEN_W-1:0]  pool_reg;
    logic [WB_W-1:0]   wb_cfg_reg;
    logic              policy_reg;

    logic [1:0]        type_reg, type_next;
    logic [ADDR_W-1:0] off_reg, off_next;
    logic [WB_W-1:0]   wb_reg, wb_next;
    logic [QUO_W-1:0]  num_reg, num_next;
    logic [WB_W-1:0]   rem_reg, rem_next;
    logic [DIV_W-1:0]  dcnt_reg, dcnt_next;
    logic [SC_W-1:0]   sc_reg, sc_next;

    logic              found_reg, found_next;
    logic [HW-1:0]     best_idx_reg, best_idx_next;
    logic [LEN_W-1:0]  best_len_reg, best_len_next;
    logic [ADDR_W-1:0] best_start_reg, best_start_next;
    logic              slot_ok_reg, slot_ok_next;
    logic [BW-1:0]     slot_reg, slot_next;
    logic [LEN_W-1:0]  blen_reg, blen_next;
    logic              have_prev_reg, have_prev_next;
    logic [ADDR_W-1:0] prev_start_reg, prev_start_next;
    logic [LEN_W-1:0]  prev_len_reg, prev_len_next;
    logic [CW-1:0]     p_reg, p_next;
    logic              have_next_reg, have_next_next;
    logic [ADDR_W-1:0] next_start_reg, next_start_next;
    logic [LEN_W-1:0]  next_len_reg, next_len_next;

    logic [CW-1:0]     hcount_reg, hcount_next;
    logic [LEN_W-1:0]  unalloc_reg, unalloc_next;
    logic [2:0]        st_reg, st_next;
    logic [ADDR_W-1:0] gr_reg, gr_next;

    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] out_gr_reg, out_gr_next;
    logic [2:0]        out_st_reg, out_st_next;
    logic [LEN_W-1:0]  out_fw_reg, out_fw_next;

    hole_ctl_t hctl;
    blk_ctl_t  bctl;

    logic [ADDR_W-1:0] h_start [MAX_HOLES];
    logic [LEN_W-1:0]  h_len   [MAX_HOLES];
    logic              b_valid [MAX_BLOCKS];
    logic [ADDR_W-1:0] b_start [MAX_BLOCKS];
    logic [LEN_W-1:0]  b_len   [MAX_BLOCKS];

    logic [LEN_W-1:0]  pool_size;
    logic              in_fire;
    logic [WB_W:0]     div_trial;
    logic [WB_W:0]     div_diff;
    logic              scan_h;
    logic              scan_b;
    logic [LEN_W-1:0]  words17;
    logic [LEN_W-1:0]  prev_end;
    logic [LEN_W-1:0]  off_end;
    logic              merge_prev;
    logic              merge_next;

    assign pool_size = (pool_reg > LIMIT) ? LIMIT : pool_reg;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign div_trial = {rem_reg, num_reg[QUO_W-1]};
    assign div_diff  = div_trial - {1'b0, wb_reg};

    assign scan_h = CMP_W'(sc_reg) < CMP_W'(MAX_HOLES);
    assign scan_b = CMP_W'(sc_reg) < CMP_W'(MAX_BLOCKS);

    assign words17    = num_reg[LEN_W-1:0];
    assign prev_end   = {1'b0, prev_start_reg} + prev_len_reg;
    assign off_end    = {1'b0, off_reg} + blen_reg;
    assign merge_prev = have_prev_reg && (prev_end == {1'b0, off_reg});
    assign merge_next = have_next_reg && (off_end == {1'b0, next_start_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_reg   <= LEN_W'(65536);
            wb_cfg_reg <= WB_W'(8);
            policy_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_POOL_WORDS: pool_reg   <= cfg_data[LEN_W-1:0];
                CFG_WORD_BYTES: wb_cfg_reg <= cfg_data[WB_W-1:0];
                CFG_FIT_POLICY: policy_reg <= cfg_data[0];
                default:        pool_reg   <= pool_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        type_next       = type_reg;
        off_next        = off_reg;
        wb_next         = wb_reg;
        num_next        = num_reg;
        rem_next        = rem_reg;
        dcnt_next       = dcnt_reg;
        sc_next         = sc_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_len_next   = best_len_reg;
        best_start_next = best_start_reg;
        slot_ok_next    = slot_ok_reg;
        slot_next       = slot_reg;
        blen_next       = blen_reg;
        have_prev_next  = have_prev_reg;
        prev_start_next = prev_start_reg;
        prev_len_next   = prev_len_reg;
        p_next          = p_reg;
        have_next_next  = have_next_reg;
        next_start_next = next_start_reg;
        next_len_next   = next_len_reg;
        hcount_next     = hcount_reg;
        unalloc_next    = unalloc_reg;
        st_next         = st_reg;
        gr_next         = gr_reg;
        out_valid_next  = out_valid_reg;
        out_gr_next     = out_gr_reg;
        out_st_next     = out_st_reg;
        out_fw_next     = out_fw_reg;
        hctl            = '{op: HOP_HOLD, idx: '0, start: '0, len: '0};
        bctl            = '{op: BOP_HOLD, idx: '0, start: '0, len: '0};

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    type_next      = req_type;
                    off_next       = block_offset;
                    wb_next        = (wb_cfg_reg == '0) ? WB_W'(1) : wb_cfg_reg;
                    num_next       = {1'b0, request_bytes} +
                                     QUO_W'((wb_cfg_reg == '0) ? WB_W'(1) : wb_cfg_reg)
                                     - QUO_W'(1);
                    rem_next       = '0;
                    dcnt_next      = '0;
                    sc_next        = '0;
                    found_next     = 1'b0;
                    slot_ok_next   = 1'b0;
                    have_prev_next = 1'b0;
                    have_next_next = 1'b0;
                    p_next         = '0;
                    st_next        = ST_OK;
                    gr_next        = '0;
                    case (req_type)
                        REQ_ALLOC:
                        begin
                            if (request_bytes == '0)
                            begin
                                st_next    = ST_ZERO;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_DIV;
                            end
                        end
                        REQ_FREE:   state_next = S_SCAN;
                        REQ_REINIT: state_next = S_EVAL;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_DIV:
            begin
                // Restoring division, one quotient bit per cycle shifted into num.
                if (div_trial >= {1'b0, wb_reg})
                begin
                    rem_next = div_diff[WB_W-1:0];
                    num_next = {num_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = div_trial[WB_W-1:0];
                    num_next = {num_reg[QUO_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + DIV_W'(1);
                if (dcnt_reg == DIV_W'(QUO_W - 1))
                begin
                    if (num_next > {{(QUO_W-LEN_W){1'b0}}, unalloc_reg})
                    begin
                        st_next    = ST_FEW;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // Entry number sc of each chain sits in cell zero this cycle.
                if (scan_h)
                begin
                    hctl.op = HOP_ROT;
                    if (CMP_W'(sc_reg) < CMP_W'(hcount_reg))
                    begin
                        if (type_reg == REQ_ALLOC)
                        begin
                            if ({{(QUO_W-LEN_W){1'b0}}, h_len[0]} >= num_reg &&
                                (!found_reg ||
                                 (policy_reg ? (h_len[0] > best_len_reg)
                                             : (h_len[0] < best_len_reg))))
                            begin
                                found_next      = 1'b1;
                                best_idx_next   = sc_reg[HW-1:0];
                                best_len_next   = h_len[0];
                                best_start_next = h_start[0];
                            end
                        end
                        else if (h_start[0] < off_reg)
                        begin
                            have_prev_next  = 1'b1;
                            prev_start_next = h_start[0];
                            prev_len_next   = h_len[0];
                            p_next          = CW'(sc_reg) + CW'(1);
                        end
                        else if (!have_next_reg)
                        begin
                            have_next_next  = 1'b1;
                            next_start_next = h_start[0];
                            next_len_next   = h_len[0];
                        end
                    end
                end
                if (scan_b)
                begin
                    bctl.op = BOP_ROT;
                    if (!slot_ok_reg)
                    begin
                        if (type_reg == REQ_ALLOC && !b_valid[0])
                        begin
                            slot_ok_next = 1'b1;
                            slot_next    = BW'(sc_reg);
                        end
                        else if (type_reg != REQ_ALLOC && b_valid[0] &&
                                 b_start[0] == off_reg)
                        begin
                            slot_ok_next = 1'b1;
                            slot_next    = BW'(sc_reg);
                            blen_next    = b_len[0];
                        end
                    end
                end
                sc_next = sc_reg + SC_W'(1);
                if (sc_reg == SC_W'(SCAN_N - 1))
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_DONE;
                case (type_reg)
                    REQ_ALLOC:
                    begin
                        if (!found_reg)
                        begin
                            st_next = ST_NOFIT;
                        end
                        else if (!slot_ok_reg)
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            bctl = '{op: BOP_SET, idx: IDX_W'(slot_reg),
                                     start: best_start_reg, len: words17};
                            if (best_len_reg > words17)
                            begin
                                hctl = '{op: HOP_UPD, idx: IDX_W'(best_idx_reg),
                                         start: best_start_reg + words17[ADDR_W-1:0],
                                         len: best_len_reg - words17};
                            end
                            else
                            begin
                                hctl = '{op: HOP_DEL, idx: IDX_W'(best_idx_reg),
                                         start: '0, len: '0};
                                hcount_next = hcount_reg - CW'(1);
                            end
                            unalloc_next = unalloc_reg - words17;
                            gr_next      = best_start_reg;
                        end
                    end
                    REQ_FREE:
                    begin
                        if (!slot_ok_reg)
                        begin
                            st_next = ST_NOTALLOC;
                        end
                        else if (!merge_prev && !merge_next &&
                                 CMP_W'(hcount_reg) >= CMP_W'(MAX_HOLES))
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            bctl = '{op: BOP_CLRV, idx: IDX_W'(slot_reg),
                                     start: '0, len: '0};
                            unalloc_next = unalloc_reg + blen_reg;
                            if (merge_prev)
                            begin
                                hctl = '{op: HOP_UPD, idx: IDX_W'(p_reg - CW'(1)),
                                         start: prev_start_reg,
                                         len: prev_len_reg + blen_reg +
                                              (merge_next ? next_len_reg : '0)};
                                if (merge_next)
                                begin
                                    state_next = S_REMOVE;
                                end
                            end
                            else if (merge_next)
                            begin
                                hctl = '{op: HOP_UPD, idx: IDX_W'(p_reg),
                                         start: off_reg, len: next_len_reg + blen_reg};
                            end
                            else
                            begin
                                hctl = '{op: HOP_INS, idx: IDX_W'(p_reg),
                                         start: off_reg, len: blen_reg};
                                hcount_next = hcount_reg + CW'(1);
                            end
                        end
                    end
                    default:
                    begin
                        hctl         = '{op: HOP_CLR, idx: '0, start: '0, len: pool_size};
                        bctl         = '{op: BOP_CLRALL, idx: '0, start: '0, len: '0};
                        hcount_next  = (pool_size == '0) ? CW'(0) : CW'(1);
                        unalloc_next = pool_size;
                    end
                endcase
            end
            S_REMOVE:
            begin
                // Both neighbors merged: the upper hole is absorbed into the lower one.
                hctl        = '{op: HOP_DEL, idx: IDX_W'(p_reg), start: '0, len: '0};
                hcount_next = hcount_reg - CW'(1);
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_gr_next    = gr_reg;
                    out_st_next    = st_reg;
                    out_fw_next    = unalloc_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hcount_reg    <= CW'(1);
            unalloc_reg   <= LIMIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hcount_reg    <= hcount_next;
            unalloc_reg   <= unalloc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg       <= type_next;
        off_reg        <= off_next;
        wb_reg         <= wb_next;
        num_reg        <= num_next;
        rem_reg        <= rem_next;
        dcnt_reg       <= dcnt_next;
        sc_reg         <= sc_next;
        found_reg      <= found_next;
        best_idx_reg   <= best_idx_next;
        best_len_reg   <= best_len_next;
        best_start_reg <= best_start_next;
        slot_ok_reg    <= slot_ok_next;
        slot_reg       <= slot_next;
        blen_reg       <= blen_next;
        have_prev_reg  <= have_prev_next;
        prev_start_reg <= prev_start_next;
        prev_len_reg   <= prev_len_next;
        p_reg          <= p_next;
        have_next_reg  <= have_next_next;
        next_start_reg <= next_start_next;
        next_len_reg   <= next_len_next;
        st_reg         <= st_next;
        gr_reg         <= gr_next;
        out_gr_reg     <= out_gr_next;
        out_st_reg     <= out_st_next;
        out_fw_reg     <= out_fw_next;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_HOLES; gi++)
        begin : g_hole
            localparam int LI = (gi == 0) ? 0 : gi - 1;
            localparam int RI = (gi == MAX_HOLES - 1) ? 0 : gi + 1;
            fac_hole_cell #(
                .IDX       (gi),
                .LAST      (gi == MAX_HOLES - 1),
                .RESET_LEN (POOL_LIMIT)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (hctl),
                .left_start  ((gi == 0) ? '0 : h_start[LI]),
                .left_len    ((gi == 0) ? '0 : h_len[LI]),
                .right_start (h_start[RI]),
                .right_len   (h_len[RI]),
                .start       (h_start[gi]),
                .len         (h_len[gi])
            );
        end
        for (gi = 0; gi < MAX_BLOCKS; gi++)
        begin : g_blk
            localparam int RI = (gi == MAX_BLOCKS - 1) ? 0 : gi + 1;
            fac_blk_cell #(
                .IDX (gi)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (bctl),
                .right_valid (b_valid[RI]),
                .right_start (b_start[RI]),
                .right_len   (b_len[RI]),
                .valid       (b_valid[gi]),
                .start       (b_start[gi]),
                .len         (b_len[gi])
            );
        end
    endgenerate

    assign out_valid      = out_valid_reg;
    assign granted_offset = out_gr_reg;
    assign status         = out_st_reg;
    assign free_words     = out_fw_reg;

endmodule
`default_nettype wire

/* rtl/fac_hole_cell.sv */
// One entry of the address-ordered hole chain.
`default_nettype none
module fac_hole_cell #(
    parameter int IDX       = 0,
    parameter bit LAST      = 1'b0,
    parameter int RESET_LEN = 65536
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire fac_pkg::hole_ctl_t          ctl,
    input  wire logic [fac_pkg::ADDR_W-1:0]  left_start,
    input  wire logic [fac_pkg::LEN_W-1:0]   left_len,
    input  wire logic [fac_pkg::ADDR_W-1:0]  right_start,
    input  wire logic [fac_pkg::LEN_W-1:0]   right_len,
    output logic      [fac_pkg::ADDR_W-1:0]  start,
    output logic      [fac_pkg::LEN_W-1:0]   len
);
    import fac_pkg::*;

    localparam logic [IDX_W-1:0] ME = IDX_W'(IDX);
    localparam logic [LEN_W-1:0] RST_LEN = (IDX == 0) ? LEN_W'(RESET_LEN) : '0;

    logic [ADDR_W-1:0] start_reg, start_next;
    logic [LEN_W-1:0]  len_reg, len_next;

    always_comb
    begin
        start_next = start_reg;
        len_next   = len_reg;
        case (ctl.op)
            HOP_ROT:
            begin
                start_next = right_start;
                len_next   = right_len;
            end
            HOP_UPD:
            begin
                if (ME == ctl.idx)
                begin
                    start_next = ctl.start;
                    len_next   = ctl.len;
                end
            end
            HOP_DEL:
            begin
                // The last entry becomes empty as the tail moves down.
                if (ME >= ctl.idx)
                begin
                    start_next = LAST ? '0 : right_start;
                    len_next   = LAST ? '0 : right_len;
                end
            end
            HOP_INS:
            begin
                if (ME == ctl.idx)
                begin
                    start_next = ctl.start;
                    len_next   = ctl.len;
                end
                else if (ME > ctl.idx)
                begin
                    start_next = left_start;
                    len_next   = left_len;
                end
            end
            HOP_CLR:
            begin
                start_next = '0;
                len_next   = (IDX == 0) ? ctl.len : '0;
            end
            default:
            begin
                start_next = start_reg;
                len_next   = len_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            len_reg   <= RST_LEN;
        end
        else
        begin
            start_reg <= start_next;
            len_reg   <= len_next;
        end
    end

    assign start = start_reg;
    assign len   = len_reg;

endmodule
`default_nettype wire

/* rtl/fac_blk_cell.sv */
// One slot of the allocated-block chain.
`default_nettype none
module fac_blk_cell #(
    parameter int IDX = 0
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire fac_pkg::blk_ctl_t           ctl,
    input  wire logic                        right_valid,
    input  wire logic [fac_pkg::ADDR_W-1:0]  right_start,
    input  wire logic [fac_pkg::LEN_W-1:0]   right_len,
    output logic                             valid,
    output logic      [fac_pkg::ADDR_W-1:0]  start,
    output logic      [fac_pkg::LEN_W-1:0]   len
);
    import fac_pkg::*;

    localparam logic [IDX_W-1:0] ME = IDX_W'(IDX);

    logic              valid_reg, valid_next;
    logic [ADDR_W-1:0] start_reg, start_next;
    logic [LEN_W-1:0]  len_reg, len_next;

    always_comb
    begin
        valid_next = valid_reg;
        start_next = start_reg;
        len_next   = len_reg;
        case (ctl.op)
            BOP_ROT:
            begin
                valid_next = right_valid;
                start_next = right_start;
                len_next   = right_len;
            end
            BOP_SET:
            begin
                if (ME == ctl.idx)
                begin
                    valid_next = 1'b1;
                    start_next = ctl.start;
                    len_next   = ctl.len;
                end
            end
            BOP_CLRV:
            begin
                if (ME == ctl.idx)
                begin
                    valid_next = 1'b0;
                end
            end
            BOP_CLRALL:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        len_reg   <= len_next;
    end

    assign valid = valid_reg;
    assign start = start_reg;
    assign len   = len_reg;

endmodule
`default_nettype wire

/* tb/fac_checker.sv */
// Watches the allocator's channels, predicts each response and compares it with the DUT.
`timescale 1ns / 1ps
module fac_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    input  wire logic                        cfg_ready,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [fac_pkg::CFG_W-1:0]   cfg_data,
    input  wire logic                        in_valid,
    input  wire logic                        in_ready,
    input  wire logic [1:0]                  req_type,
    input  wire logic [fac_pkg::BYTES_W-1:0] request_bytes,
    input  wire logic [fac_pkg::ADDR_W-1:0]  block_offset,
    input  wire logic                        out_valid,
    input  wire logic                        out_ready,
    input  wire logic [fac_pkg::ADDR_W-1:0]  granted_offset,
    input  wire logic [2:0]                  status,
    input  wire logic [fac_pkg::LEN_W-1:0]   free_words,
    output int                               fail_count,
    output int                               pending
);
    import fac_pkg::*;

    localparam int NHOLES  = DEF_MAX_HOLES;
    localparam int NBLOCKS = DEF_MAX_BLOCKS;

    typedef struct {
        logic [ADDR_W-1:0] grant;
        logic [2:0]        st;
        logic [LEN_W-1:0]  fw;
    } fac_result_t;

    fac_result_t expected_q[$];

    int unsigned pool_cfg, wbytes_cfg, policy_cfg;
    int unsigned hole_at[NHOLES], hole_len[NHOLES], holes;
    int unsigned blk_at[NBLOCKS], blk_len[NBLOCKS];
    bit          blk_live[NBLOCKS];
    int unsigned unalloc;

    assign pending = expected_q.size();

    function automatic void rebuild_pool();
        int unsigned sz;
        sz = pool_cfg > DEF_POOL_LIMIT ? DEF_POOL_LIMIT : pool_cfg;
        for (int i = 0; i < NHOLES; i++) begin
            hole_at[i]  = 0;
            hole_len[i] = 0;
        end
        for (int i = 0; i < NBLOCKS; i++) begin
            blk_at[i]   = 0;
            blk_len[i]  = 0;
            blk_live[i] = 0;
        end
        holes = (sz == 0) ? 0 : 1;
        hole_len[0] = sz;
        unalloc = sz;
    endfunction

    function automatic void drop_hole(int unsigned p);
        for (int unsigned i = p; i + 1 < holes; i++) begin
            hole_at[i]  = hole_at[i + 1];
            hole_len[i] = hole_len[i + 1];
        end
        holes--;
        hole_at[holes]  = 0;
        hole_len[holes] = 0;
    endfunction

    function automatic logic [2:0] allocate(int unsigned nbytes, output int unsigned grant);
        int unsigned wb, words, pick, picklen, slot;
        bit found;
        grant = 0;
        found = 0;
        pick = 0;
        picklen = 0;
        wb = (wbytes_cfg == 0) ? 1 : wbytes_cfg;
        if (nbytes == 0)
            return ST_ZERO;
        words = (nbytes + wb - 1) / wb;
        if (words > unalloc)
            return ST_FEW;
        for (int unsigned i = 0; i < holes; i++) begin
            if (hole_len[i] >= words &&
                (!found || (policy_cfg != 0 ? hole_len[i] > picklen : hole_len[i] < picklen)))
            begin
                found = 1;
                pick = i;
                picklen = hole_len[i];
            end
        end
        if (!found)
            return ST_NOFIT;
        slot = NBLOCKS;
        for (int i = NBLOCKS - 1; i >= 0; i--)
            if (!blk_live[i])
                slot = i;
        if (slot >= NBLOCKS)
            return ST_FULL;
        blk_live[slot] = 1;
        blk_at[slot] = hole_at[pick];
        blk_len[slot] = words;
        grant = hole_at[pick];
        if (picklen > words) begin
            hole_at[pick] += words;
            hole_len[pick] = picklen - words;
        end else begin
            drop_hole(pick);
        end
        unalloc -= words;
        return ST_OK;
    endfunction

    function automatic logic [2:0] release_block(int unsigned off);
        int unsigned slot, len, p;
        bit join_prev, join_next;
        slot = NBLOCKS;
        for (int i = NBLOCKS - 1; i >= 0; i--)
            if (blk_live[i] && blk_at[i] == off)
                slot = i;
        if (slot >= NBLOCKS)
            return ST_NOTALLOC;
        len = blk_len[slot];
        p = 0;
        while (p < holes && hole_at[p] < off)
            p++;
        join_prev = p > 0 && hole_at[p - 1] + hole_len[p - 1] == off;
        join_next = p < holes && off + len == hole_at[p];
        if (!join_prev && !join_next && holes >= NHOLES)
            return ST_FULL;
        blk_live[slot] = 0;
        unalloc += len;
        if (join_prev) begin
            hole_len[p - 1] += len;
            if (join_next) begin
                hole_len[p - 1] += hole_len[p];
                drop_hole(p);
            end
        end else if (join_next) begin
            hole_at[p] = off;
            hole_len[p] += len;
        end else begin
            for (int unsigned i = holes; i > p; i--) begin
                hole_at[i]  = hole_at[i - 1];
                hole_len[i] = hole_len[i - 1];
            end
            hole_at[p] = off;
            hole_len[p] = len;
            holes++;
        end
        return ST_OK;
    endfunction

    function automatic fac_result_t predict_response(logic [1:0] kind, int unsigned nbytes,
                                                     int unsigned off);
        fac_result_t r;
        int unsigned g;
        g = 0;
        r.st = ST_OK;
        if (kind == REQ_ALLOC)
            r.st = allocate(nbytes, g);
        else if (kind == REQ_FREE)
            r.st = release_block(off);
        else if (kind == REQ_REINIT)
            rebuild_pool();
        r.grant = g[ADDR_W-1:0];
        r.fw = unalloc[LEN_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t mismatch on %s: got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        fac_result_t e;
        if (!rst_n) begin
            pool_cfg   = DEF_POOL_LIMIT;
            wbytes_cfg = 8;
            policy_cfg = 0;
            rebuild_pool();
            expected_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_POOL_WORDS)
                    pool_cfg = cfg_data;
                else if (cfg_index == CFG_WORD_BYTES)
                    wbytes_cfg = cfg_data[WB_W-1:0];
                else if (cfg_index == CFG_FIT_POLICY)
                    policy_cfg = cfg_data[0];
            end
            if (out_valid && out_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("response beat count", 1, 0);
                end else begin
                    e = expected_q.pop_front();
                    if (granted_offset !== e.grant)
                        report_mismatch("granted_offset", granted_offset, e.grant);
                    if (status !== e.st)
                        report_mismatch("status", status, e.st);
                    if (free_words !== e.fw)
                        report_mismatch("free_words", free_words, e.fw);
                end
            end
            if (in_valid && in_ready)
                expected_q.push_back(predict_response(req_type, request_bytes, block_offset));
        end
    end

endmodule

/* tb/tb_top.sv */
// Top of the allocator testbench: clock, reset, request stimulus and the verdict.
`timescale 1ns / 1ps
module tb_top;
    import fac_pkg::*;

    // Request code the block answers without acting on it.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         req_type;
    logic [BYTES_W-1:0] request_bytes;
    logic [ADDR_W-1:0]  block_offset;
    logic               out_valid;
    logic               out_ready;
    logic [ADDR_W-1:0]  granted_offset;
    logic [2:0]         status;
    logic [LEN_W-1:0]   free_words;
    int                 fail_count;
    int                 pending;

    bit                 quiet;
    bit                 long_hold;
    logic [1:0]         sent_kinds[$];
    logic [ADDR_W-1:0]  live_offsets[$];

    fit_allocator_with_coalescing_core DUT (.*);

    fac_checker u_checker (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    initial
    begin
        #30_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Track which allocations succeeded so frees can target live blocks.
    always @(posedge clk)
    begin
        logic [1:0] k;
        if (rst_n) begin
            if (in_valid && in_ready)
                sent_kinds.push_back(req_type);
            if (out_valid && out_ready && sent_kinds.size() > 0) begin
                k = sent_kinds.pop_front();
                if (k == REQ_ALLOC && status == ST_OK)
                    live_offsets.push_back(granted_offset);
            end
        end
    end

    initial
    begin
        int lo;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold) begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                long_hold = 0;
            end
            lo = pick_gap();
            if (lo > 0) begin
                out_ready <= 1'b0;
                repeat (lo) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 8) - 1) @(posedge clk);
        end
    end

    task automatic send_request(logic [1:0] kind, logic [BYTES_W-1:0] nbytes,
                                logic [ADDR_W-1:0] off);
        int g;
        in_valid      <= 1'b1;
        req_type      <= kind;
        request_bytes <= nbytes;
        block_offset  <= off;
        do @(posedge clk); while (!in_ready);
        g = pick_gap();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic load_settings(int unsigned pw, int unsigned wb, int unsigned fp);
        wait_drained();
        write_reg(CFG_POOL_WORDS, CFG_W'(pw));
        write_reg(CFG_WORD_BYTES, CFG_W'(wb));
        write_reg(CFG_FIT_POLICY, CFG_W'(fp));
        cfg_valid <= 1'b0;
        live_offsets.delete();
        send_request(REQ_REINIT, BYTES_W'($urandom), ADDR_W'($urandom));
    endtask

    task automatic random_request();
        int r, idx;
        logic [BYTES_W-1:0] nb;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            idx = $urandom_range(0, 99);
            if (idx < 70)
                nb = BYTES_W'($urandom_range(1, 300));
            else if (idx < 85)
                nb = BYTES_W'($urandom_range(1, 5000));
            else if (idx < 95)
                nb = BYTES_W'($urandom);
            else
                nb = '0;
            send_request(REQ_ALLOC, nb, ADDR_W'($urandom));
        end else if (r < 90) begin
            if (live_offsets.size() > 0 && $urandom_range(0, 99) < 85) begin
                idx = $urandom_range(0, live_offsets.size() - 1);
                send_request(REQ_FREE, BYTES_W'($urandom), live_offsets[idx]);
                live_offsets.delete(idx);
            end else begin
                send_request(REQ_FREE, BYTES_W'($urandom), ADDR_W'($urandom));
            end
        end else if (r < 93) begin
            live_offsets.delete();
            send_request(REQ_REINIT, BYTES_W'($urandom), ADDR_W'($urandom));
        end else begin
            send_request(REQ_UNUSED, BYTES_W'($urandom), ADDR_W'($urandom));
        end
    endtask

    initial
    begin
        int unsigned pools[9]  = '{256, 1, 65536, 131071, 0, 4000, 65536, 100, 700};
        int unsigned wbytes[9] = '{4, 1, 16, 31, 0, 8, 1, 3, 16};
        int unsigned fits[9]   = '{0, 1, 1, 0, 0, 1, 0, 1, 0};
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_POOL_WORDS;
        cfg_data = '0;
        in_valid = 1'b0;
        req_type = REQ_ALLOC;
        request_bytes = '0;
        block_offset = '0;
        quiet = 0;
        long_hold = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset settings.
        send_request(REQ_ALLOC, BYTES_W'(0), 16'hFFFF);
        send_request(REQ_ALLOC, {BYTES_W{1'b1}}, ADDR_W'(0));
        send_request(REQ_ALLOC, BYTES_W'(1), ADDR_W'(0));
        send_request(REQ_ALLOC, BYTES_W'(9), ADDR_W'(0));
        send_request(REQ_FREE, BYTES_W'(0), 16'hFFFF);
        send_request(REQ_FREE, BYTES_W'(0), ADDR_W'(1));
        send_request(REQ_FREE, BYTES_W'(0), ADDR_W'(0));
        send_request(REQ_FREE, BYTES_W'(0), ADDR_W'(0));
        send_request(REQ_UNUSED, {BYTES_W{1'b1}}, 16'hFFFF);
        send_request(REQ_ALLOC, BYTES_W'(524288), ADDR_W'(0));
        send_request(REQ_ALLOC, BYTES_W'(1), ADDR_W'(0));
        send_request(REQ_FREE, BYTES_W'(0), ADDR_W'(0));
        send_request(REQ_ALLOC, BYTES_W'(524289), ADDR_W'(0));
        send_request(REQ_ALLOC, BYTES_W'(1048576), ADDR_W'(0));
        send_request(REQ_REINIT, BYTES_W'(0), ADDR_W'(0));

        // Fill the block table past its end, then run random requests until no block is live.
        load_settings(65536, 1, 0);
        repeat (66) send_request(REQ_ALLOC, BYTES_W'($urandom_range(1, 40)),
                                 ADDR_W'($urandom));
        wait_drained();
        while (live_offsets.size() > 0) random_request();

        for (int ph = 0; ph < 9; ph++)
        begin
            load_settings(pools[ph], wbytes[ph], fits[ph]);
            quiet = (ph == 3);
            for (int n = 0; n < 140; n++)
            begin
                if (ph == 2 && n == 20)
                    long_hold = 1;
                random_request();
            end
        end
        quiet = 0;

        wait_drained();
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/fac_pkg.sv
rtl/fac_hole_cell.sv
rtl/fac_blk_cell.sv
rtl/fit_allocator_with_coalescing_core.sv
tb/fac_checker.sv
tb/tb_top.sv
